/* sv/mmpl2_pkg.sv */
// ----------------------------------------------------------------------------
// mmpl2_pkg
// shared types and fixed constants for the masked mean pool / l2 normalize unit
// ----------------------------------------------------------------------------
package mmpl2_pkg;

	localparam int ACC_W   = 26;
	localparam int CNT_W   = 10;
	localparam int SQ_W    = 64;
	localparam int NORM_W  = 32;
	localparam int QUO_W   = 17;
	localparam int LIM_W   = 11;
	localparam int OUT_LANES = 8;

	localparam logic [CNT_W-1:0] COUNT_MAX = 10'd1023;
	localparam logic [2:0]       REG_ACTIVE_DIMS = 3'd0;
	localparam logic [8:0]       ACTIVE_DIMS_RESET = 9'd384;

	typedef struct packed {
		logic signed [15:0] value;
		logic [8:0]         dim_index;
		logic               token_valid;
		logic               end_of_sequence;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] lane0;
		logic signed [15:0] lane1;
		logic signed [15:0] lane2;
		logic signed [15:0] lane3;
		logic signed [15:0] lane4;
		logic signed [15:0] lane5;
		logic signed [15:0] lane6;
		logic signed [15:0] lane7;
		logic [5:0]         group_index;
		logic               last_group;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_ACC,
		ST_DRAIN,
		ST_SUMSQ,
		ST_SQWAIT,
		ST_SQRT,
		ST_LREAD,
		ST_LWAIT,
		ST_LDIV,
		ST_EMIT
	} state_t;

	// saturate a rounded quotient into q1.15 with its sign applied
	function automatic logic [15:0] lane_sat(input logic neg, input logic sat,
		input logic [QUO_W-1:0] q);
		logic [QUO_W-1:0] qc;
		begin
			qc = q;
			if (neg) begin
				if (sat || q > 17'd32768) qc = 17'd32768;
			end else begin
				if (sat || q > 17'd32767) qc = 17'd32767;
			end
			lane_sat = neg ? 16'(17'd0 - qc) : qc[15:0];
		end
	endfunction

endpackage

/* sv/masked_mean_pool_l2_normalize_unit.sv */
// ----------------------------------------------------------------------------
// masked_mean_pool_l2_normalize_unit
// masked mean pooling of hidden states followed by l2 normalization
// ----------------------------------------------------------------------------
// Takes one hidden-state element per cycle while accumulating: each request
// adds its Q4.12 value into a saturating 26-bit per-dimension sum held in a
// single-port-write, single-port-read synchronous memory (read, add, write
// back in the following cycle, with forwarding for back-to-back hits on the same
// dimension). The request marked end_of_sequence starts the output pass and
// the input stalls until the last result is taken: a drain state, a sweep
// over all HIDDEN_DIMS entries for the sum of squares, the bit-pair square
// root, then per group of 8 lanes a read and a wait for each lane plus a
// shift-subtract division for each active lane whose quotient does not
// saturate, and a handoff for each group. Entries are cleared to zero as
// they are read out.
// After reset a clearing pass over all HIDDEN_DIMS entries runs before the
// first request is taken; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module masked_mean_pool_l2_normalize_unit #(
	parameter int HIDDEN_DIMS = 384,
	parameter int LANES       = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input requests
	input  logic                 in_valid,
	output logic                 in_stall,
	input  mmpl2_pkg::in_item_t  in_data,
	// results
	output logic                 out_valid,
	input  logic                 out_stall,
	output mmpl2_pkg::out_item_t out_data,
	// register port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int DW     = $clog2(HIDDEN_DIMS);
	localparam int GROUPS = (HIDDEN_DIMS + LANES - 1) / LANES;
	localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int AW     = mmpl2_pkg::ACC_W;
	localparam int LW     = mmpl2_pkg::LIM_W;

	localparam logic signed [AW:0] ACC_MAX = (AW+1)'((1 << (AW-1)) - 1);
	localparam logic signed [AW:0] ACC_MIN = -(AW+1)'(1 << (AW-1));

	// ------------------------------------------------------------------
	// configuration
	// ------------------------------------------------------------------
	logic [8:0]    active_dims_q;
	logic [LW-1:0] lim;

	assign pready = 1'b1;
	assign prdata = {23'd0, active_dims_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_dims_q <= mmpl2_pkg::ACTIVE_DIMS_RESET;
		end else if (psel && penable && pwrite && paddr == mmpl2_pkg::REG_ACTIVE_DIMS) begin
			active_dims_q <= pwdata[8:0];
		end
	end

	// values above the array size act as the array size
	assign lim = (LW'(active_dims_q) > LW'(HIDDEN_DIMS)) ? LW'(HIDDEN_DIMS) : LW'(active_dims_q);

	// ------------------------------------------------------------------
	// accumulator memory
	// ------------------------------------------------------------------
	logic [AW-1:0] acc_mem [HIDDEN_DIMS];
	logic [AW-1:0] rdata_q;
	logic [DW-1:0] rd_addr;
	logic          rd_en;
	logic [DW-1:0] wr_addr;
	logic [AW-1:0] wr_data;
	logic          wr_en;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= acc_mem[rd_addr];
		end
		if (wr_en) begin
			acc_mem[wr_addr] <= wr_data;
		end
	end

	// ------------------------------------------------------------------
	// state
	// ------------------------------------------------------------------
	mmpl2_pkg::state_t state_q, state_d;

	logic              in_acc;
	logic              out_acc;
	logic [DW-1:0]     idx_q;         // sweep index for clear and sum of squares
	logic [mmpl2_pkg::CNT_W-1:0] cnt_q;

	// accumulate pipeline
	logic              acc_v_s1;
	logic [DW-1:0]     acc_addr_s1;
	logic signed [15:0] acc_val_s1;
	logic              fwd_v_q;
	logic [DW-1:0]     fwd_addr_q;
	logic [AW-1:0]     fwd_data_q;
	logic signed [AW-1:0] acc_base;
	logic signed [AW:0]   acc_sum;
	logic [AW-1:0]     acc_new;

	// sum of squares pipeline
	logic              sq_v_s1;
	logic              sq_in_s1;
	logic              sq_v_s2;
	logic [2*AW-1:0]   sq_prod_s2;
	logic [mmpl2_pkg::SQ_W-1:0] sumsq_q;
	logic [AW-1:0]     rd_mag;

	// square root
	logic [mmpl2_pkg::SQ_W-1:0] x_q, r_q, bit_q;
	logic [mmpl2_pkg::SQ_W-1:0] rb;
	logic              sq_ge;
	logic [mmpl2_pkg::SQ_W-1:0] r_next;
	logic [mmpl2_pkg::NORM_W-1:0] norm_q;
	logic              zero_q;

	// lane division
	logic [GW-1:0]     grp_q;
	logic [2:0]        lane_q;
	logic [LW-1:0]     dcur;
	logic              lane_live;
	logic              lane_mem;
	logic              neg_q;
	logic [mmpl2_pkg::NORM_W:0] den;
	logic [41:0]       num;
	logic [32:0]       rem_q;
	logic [33:0]       rem_t;
	logic [16:0]       num_lo_q;
	logic [mmpl2_pkg::QUO_W-1:0] quo_q;
	logic [4:0]        div_cnt_q;
	logic [15:0]       lanes_q [mmpl2_pkg::OUT_LANES];
	logic              last_grp;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign in_stall  = (state_q != mmpl2_pkg::ST_ACC);
	assign out_valid = (state_q == mmpl2_pkg::ST_EMIT);
	assign last_grp  = (grp_q == GW'(GROUPS - 1));

	// dimension handled by the current lane
	assign dcur      = LW'(grp_q) * LW'(LANES) + LW'(lane_q);
	assign lane_mem  = (LW'(lane_q) < LW'(LANES)) && (dcur < LW'(HIDDEN_DIMS));
	assign lane_live = !zero_q && (LW'(lane_q) < LW'(LANES)) && (dcur < lim);

	// magnitude of the word just read
	assign rd_mag = rdata_q[AW-1] ? (AW)'(-rdata_q) : rdata_q;

	// saturating add with forwarding from the previous write
	assign acc_base = (fwd_v_q && fwd_addr_q == acc_addr_s1) ? fwd_data_q : rdata_q;
	assign acc_sum  = (AW+1)'(acc_base) + (AW+1)'(acc_val_s1);
	always_comb begin
		if (acc_sum > ACC_MAX)      acc_new = ACC_MAX[AW-1:0];
		else if (acc_sum < ACC_MIN) acc_new = ACC_MIN[AW-1:0];
		else                        acc_new = acc_sum[AW-1:0];
	end

	// square root step
	assign rb     = r_q + bit_q;
	assign sq_ge  = (x_q >= rb);
	assign r_next = sq_ge ? ((r_q >> 1) + bit_q) : (r_q >> 1);

	// division: numerator m * 65536 + norm, denominator 2 * norm
	assign den   = {norm_q, 1'b0};
	assign num   = {rd_mag, 16'd0} + 42'(norm_q);
	assign rem_t = {rem_q, num_lo_q[16]};

	// memory port selection
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q;
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = '0;
		case (state_q)
			mmpl2_pkg::ST_ACC: begin
				rd_en   = in_acc;
				rd_addr = DW'(in_data.dim_index);
			end
			mmpl2_pkg::ST_SUMSQ: begin
				rd_en = 1'b1;
			end
			mmpl2_pkg::ST_LREAD: begin
				rd_en   = lane_mem;
				rd_addr = dcur[DW-1:0];
				wr_en   = lane_mem;
				wr_addr = dcur[DW-1:0];
			end
			mmpl2_pkg::ST_CLEAR: begin
				wr_en = 1'b1;
			end
			default: ;
		endcase
		// the write-back stage only runs in accumulate and drain
		if (acc_v_s1) begin
			wr_en   = 1'b1;
			wr_addr = acc_addr_s1;
			wr_data = acc_new;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mmpl2_pkg::ST_CLEAR:
				if (idx_q == DW'(HIDDEN_DIMS - 1)) state_d = mmpl2_pkg::ST_ACC;
			mmpl2_pkg::ST_ACC:
				if (in_acc && in_data.end_of_sequence) state_d = mmpl2_pkg::ST_DRAIN;
			mmpl2_pkg::ST_DRAIN:
				state_d = mmpl2_pkg::ST_SUMSQ;
			mmpl2_pkg::ST_SUMSQ:
				if (idx_q == DW'(HIDDEN_DIMS - 1)) state_d = mmpl2_pkg::ST_SQWAIT;
			mmpl2_pkg::ST_SQWAIT:
				if (!sq_v_s1 && !sq_v_s2) state_d = mmpl2_pkg::ST_SQRT;
			mmpl2_pkg::ST_SQRT:
				if (bit_q == 64'd1) state_d = mmpl2_pkg::ST_LREAD;
			mmpl2_pkg::ST_LREAD:
				state_d = mmpl2_pkg::ST_LWAIT;
			mmpl2_pkg::ST_LWAIT: begin
				if (lane_live && (34'(num[41:17]) < 34'(den))) begin
					state_d = mmpl2_pkg::ST_LDIV;
				end else if (lane_q == 3'd7) begin
					state_d = mmpl2_pkg::ST_EMIT;
				end else begin
					state_d = mmpl2_pkg::ST_LREAD;
				end
			end
			mmpl2_pkg::ST_LDIV:
				if (div_cnt_q == 5'd0) begin
					state_d = (lane_q == 3'd7) ? mmpl2_pkg::ST_EMIT : mmpl2_pkg::ST_LREAD;
				end
			mmpl2_pkg::ST_EMIT:
				if (out_acc) begin
					state_d = last_grp ? mmpl2_pkg::ST_ACC : mmpl2_pkg::ST_LREAD;
				end
			default:
				state_d = mmpl2_pkg::ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmpl2_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			cnt_q    <= '0;
			acc_v_s1 <= 1'b0;
			fwd_v_q  <= 1'b0;
			sq_v_s1  <= 1'b0;
			sq_v_s2  <= 1'b0;
			grp_q    <= '0;
			lane_q   <= '0;
			div_cnt_q <= '0;
		end else begin
			acc_v_s1 <= in_acc && in_data.token_valid && (LW'(in_data.dim_index) < lim);
			fwd_v_q  <= acc_v_s1;
			sq_v_s1  <= (state_q == mmpl2_pkg::ST_SUMSQ);
			sq_v_s2  <= sq_v_s1 && sq_in_s1;

			if (in_acc && in_data.token_valid && in_data.dim_index == 9'd0
				&& cnt_q < mmpl2_pkg::COUNT_MAX) begin
				cnt_q <= cnt_q + 1'b1;
			end

			case (state_q)
				mmpl2_pkg::ST_CLEAR, mmpl2_pkg::ST_SUMSQ:
					idx_q <= (idx_q == DW'(HIDDEN_DIMS - 1)) ? '0 : idx_q + 1'b1;
				mmpl2_pkg::ST_SQRT:
					if (bit_q == 64'd1) begin
						grp_q  <= '0;
						lane_q <= '0;
						cnt_q  <= '0;
					end
				mmpl2_pkg::ST_LWAIT: begin
					if (lane_live && (34'(num[41:17]) < 34'(den))) begin
						div_cnt_q <= 5'd16;
					end else if (lane_q != 3'd7) begin
						lane_q <= lane_q + 1'b1;
					end
				end
				mmpl2_pkg::ST_LDIV: begin
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == 5'd0 && lane_q != 3'd7) begin
						lane_q <= lane_q + 1'b1;
					end
				end
				mmpl2_pkg::ST_EMIT:
					if (out_acc && !last_grp) begin
						grp_q  <= grp_q + 1'b1;
						lane_q <= '0;
					end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		acc_addr_s1 <= DW'(in_data.dim_index);
		acc_val_s1  <= in_data.value;
		fwd_addr_q  <= acc_addr_s1;
		fwd_data_q  <= acc_new;
		sq_in_s1    <= (LW'(idx_q) < lim);
		sq_prod_s2  <= (2*AW)'(rd_mag) * (2*AW)'(rd_mag);

		case (state_q)
			mmpl2_pkg::ST_DRAIN:
				sumsq_q <= '0;
			mmpl2_pkg::ST_SUMSQ, mmpl2_pkg::ST_SQWAIT: begin
				if (sq_v_s2) sumsq_q <= sumsq_q + 64'(sq_prod_s2);
				// square root starts from the full word
				x_q   <= sumsq_q + (sq_v_s2 ? 64'(sq_prod_s2) : 64'd0);
				r_q   <= '0;
				bit_q <= 64'd1 << 62;
			end
			mmpl2_pkg::ST_SQRT: begin
				if (sq_ge) x_q <= x_q - rb;
				r_q   <= r_next;
				bit_q <= bit_q >> 2;
				if (bit_q == 64'd1) begin
					norm_q <= r_next[mmpl2_pkg::NORM_W-1:0];
					zero_q <= (cnt_q == '0) || (r_next == '0);
				end
			end
			mmpl2_pkg::ST_LWAIT: begin
				neg_q    <= rdata_q[AW-1];
				rem_q    <= 33'(num[41:17]);
				num_lo_q <= num[16:0];
				quo_q    <= '0;
				if (!lane_live) begin
					lanes_q[lane_q] <= '0;
				end else if (34'(num[41:17]) >= 34'(den)) begin
					lanes_q[lane_q] <= mmpl2_pkg::lane_sat(rdata_q[AW-1], 1'b1, '0);
				end
			end
			mmpl2_pkg::ST_LDIV: begin
				num_lo_q <= {num_lo_q[15:0], 1'b0};
				if (rem_t >= 34'(den)) begin
					rem_q <= 33'(rem_t - 34'(den));
					quo_q <= {quo_q[15:0], 1'b1};
				end else begin
					rem_q <= rem_t[32:0];
					quo_q <= {quo_q[15:0], 1'b0};
				end
				if (div_cnt_q == 5'd0) begin
					lanes_q[lane_q] <= mmpl2_pkg::lane_sat(neg_q, 1'b0,
						{quo_q[15:0], (rem_t >= 34'(den))});
				end
			end
			default: ;
		endcase
	end

	// result payload
	assign out_data.lane0 = lanes_q[0];
	assign out_data.lane1 = lanes_q[1];
	assign out_data.lane2 = lanes_q[2];
	assign out_data.lane3 = lanes_q[3];
	assign out_data.lane4 = lanes_q[4];
	assign out_data.lane5 = lanes_q[5];
	assign out_data.lane6 = lanes_q[6];
	assign out_data.lane7 = lanes_q[7];
	assign out_data.group_index = 6'(grp_q);
	assign out_data.last_group  = last_grp;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_no_input_while_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while a result is pending");

	a_back_to_accumulate: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && out_data.last_group) |=> (!out_valid && !in_stall))
		else $error("block did not return to accumulation after last group");

	a_next_group_computed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !out_data.last_group) |=> !out_valid)
		else $error("next group presented without being computed");

	a_count_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && out_data.last_group) |=> (cnt_q == '0 || in_valid))
		else $error("token count not cleared after output");

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks pooled and normalized embeddings against a cycle-free software copy
// ----------------------------------------------------------------------------
// Sends sequences of hidden-state elements, computes the normalized lanes of
// each sequence in a scoreboard, and compares every result field by field.
// Sender gaps and receiver stalls vary by phase; active_dims is rewritten
// between phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb;

	localparam int DIMS   = 384;
	localparam int GROUPS = 48;
	localparam longint LIMIT = 10000000;

	// scoreboard: running sums per dimension and the embeddings still owed
	class embed_scoreboard;
		int          sums[DIMS];
		int unsigned tokens;
		int unsigned dims_used;
		mmpl2_pkg::out_item_t pending_groups[$];
		int          errors;

		function new();
			foreach (sums[i]) sums[i] = 0;
			tokens = 0;
			dims_used = DIMS;
			errors = 0;
		endfunction

		function longint unsigned root(longint unsigned x);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > x) b >>= 2;
			while (b != 0) begin
				if (x >= r + b) begin
					x -= r + b;
					r = (r >> 1) + b;
				end else r >>= 1;
				b >>= 2;
			end
			return r;
		endfunction

		function logic [15:0] scale(int a, longint unsigned nrm);
			longint unsigned m, q;
			m = (a < 0) ? -a : a;
			q = (m * 65536 + nrm) / (2 * nrm);
			if (a < 0) begin
				if (q > 32768) q = 32768;
				return 16'(65536 - q);
			end
			if (q > 32767) q = 32767;
			return q[15:0];
		endfunction

		function void note_request(mmpl2_pkg::in_item_t it);
			int s;
			longint unsigned sq, nrm, m;
			bit zero;
			logic [15:0] ln[8];
			mmpl2_pkg::out_item_t o;
			if (it.token_valid && it.dim_index < dims_used) begin
				s = sums[it.dim_index] + int'(it.value);
				if (s > 33554431) s = 33554431;
				if (s < -33554432) s = -33554432;
				sums[it.dim_index] = s;
			end
			if (it.token_valid && it.dim_index == 0 && tokens < 1023) tokens++;
			if (!it.end_of_sequence) return;
			sq = 0;
			for (int d = 0; d < dims_used; d++) begin
				m = (sums[d] < 0) ? -sums[d] : sums[d];
				sq += m * m;
			end
			nrm = root(sq);
			zero = (tokens == 0) || (nrm == 0);
			for (int g = 0; g < GROUPS; g++) begin
				for (int l = 0; l < 8; l++)
					ln[l] = (!zero && g * 8 + l < dims_used) ? scale(sums[g * 8 + l], nrm)
						: 16'd0;
				o.lane0 = ln[0]; o.lane1 = ln[1]; o.lane2 = ln[2]; o.lane3 = ln[3];
				o.lane4 = ln[4]; o.lane5 = ln[5]; o.lane6 = ln[6]; o.lane7 = ln[7];
				o.group_index = 6'(g);
				o.last_group = (g == GROUPS - 1);
				pending_groups = {pending_groups, o};
			end
			foreach (sums[i]) sums[i] = 0;
			tokens = 0;
		endfunction

		function void check_lane(string name, logic [15:0] e, logic [15:0] g);
			if (g !== e) begin
				$error("%s exp %0d got %0d", name, $signed(e), $signed(g));
				errors++;
			end
		endfunction

		function void check_result(mmpl2_pkg::out_item_t got);
			mmpl2_pkg::out_item_t e;
			if (pending_groups.size() == 0) begin
				$error("unexpected result group %0d", got.group_index);
				errors++;
				return;
			end
			e = pending_groups.pop_front();
			check_lane("lane0", e.lane0, got.lane0);
			check_lane("lane1", e.lane1, got.lane1);
			check_lane("lane2", e.lane2, got.lane2);
			check_lane("lane3", e.lane3, got.lane3);
			check_lane("lane4", e.lane4, got.lane4);
			check_lane("lane5", e.lane5, got.lane5);
			check_lane("lane6", e.lane6, got.lane6);
			check_lane("lane7", e.lane7, got.lane7);
			if (got.group_index !== e.group_index) begin
				$error("group_index exp %0d got %0d", e.group_index, got.group_index);
				errors++;
			end
			if (got.last_group !== e.last_group) begin
				$error("last_group exp %0d got %0d", e.last_group, got.last_group);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid;
	logic out_stall = 1'b0;
	mmpl2_pkg::in_item_t in_data;
	mmpl2_pkg::out_item_t out_data;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;

	embed_scoreboard sb;
	int gap_pct, stall_pct;
	longint cycles = 0;

	masked_mean_pool_l2_normalize_unit u_top (.*);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	initial begin
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// receiver: random stalls, results checked on acceptance
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(out_data);
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("masked_mean_pool_l2_normalize_unit verification failed");
			$finish;
		end
	end

	// one request, held until accepted; gaps drawn before it
	task automatic send_request(logic signed [15:0] v, int d, bit tv, bit eos);
		mmpl2_pkg::in_item_t it;
		it.value = v;
		it.dim_index = 9'(d);
		it.token_valid = tv;
		it.end_of_sequence = eos;
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_data <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(it);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending_groups.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_active_dims(int n);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 3'(mmpl2_pkg::REG_ACTIVE_DIMS); pwdata <= 32'(n);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		sb.dims_used = (n > DIMS) ? DIMS : n;
	endtask

	int dims_set[6] = '{384, 1, 511, 17, 0, 8};
	int issued;
	int nseq;

	// a random sequence: mostly valid tokens over a few dimensions
	task automatic send_sequence(int ndims, int ntok);
		bit tv;
		logic signed [15:0] v;
		for (int t = 0; t < ntok; t++) begin
			tv = ($urandom_range(9) != 0);
			for (int d = 0; d < ndims; d++) begin
				v = ($urandom_range(5) == 0) ? (($urandom_range(1)) ? 16'sh7fff : -16'sh8000)
					: 16'($urandom);
				send_request(v, (($urandom_range(19) == 0) ? $urandom_range(511) : d), tv,
					(t == ntok - 1) && (d == ndims - 1));
				issued++;
			end
		end
	endtask

	initial begin
		sb = new();
		in_valid = 1'b0; in_data = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		gap_pct = 0; stall_pct = 0;
		@(posedge arst_n);
		@(posedge clk);

		// directed: extremes, masked token, out-of-range dim, empty sequence
		send_request(16'sh7fff, 0, 1, 0);
		send_request(-16'sh8000, 1, 1, 0);
		send_request(16'sh0001, 383, 1, 0);
		send_request(16'sh1234, 5, 0, 0);
		send_request(16'sh7fff, 511, 1, 0);
		send_request(-16'sh0001, 2, 1, 1);
		send_request(16'sh1000, 3, 0, 1);        // no valid token
		send_request(16'sh0000, 0, 1, 1);        // zero norm
		send_request(-16'sh1000, 0, 1, 0);       // single negative: exactly -1.0
		send_request(16'sh0000, 1, 1, 1);
		for (int i = 0; i < 6; i++) send_request(16'sh7fff, 0, 1, i == 5); // full-scale repeats
		wait_drained();

		issued = 0;
		for (int ph = 0; ph < 6; ph++) begin
			write_active_dims(dims_set[ph]);
			case (ph % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 80; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 80; end
				default: begin gap_pct = 9; stall_pct = 9; end
			endcase
			nseq = 0;
			while (issued < (ph + 1) * 25) begin
				send_sequence($urandom_range(1, 6), $urandom_range(1, 3));
				if (nseq == 1) wait_drained(); // sender holds off until all groups are back
				nseq++;
			end
			wait_drained();
		end

		if (sb.errors == 0 && sb.pending_groups.size() == 0)
			$display("masked_mean_pool_l2_normalize_unit verification clean");
		else
			$display("masked_mean_pool_l2_normalize_unit verification failed");
		$finish;
	end
endmodule
